FILE: sv/rita_pkg.sv
// Shared constants and character helpers for the radix integer to ASCII converter.
package rita_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned DIGIT_DEPTH = 32;
  localparam int unsigned RADIX_W     = 5;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned FLAGS_W     = 2;

  localparam int unsigned DIV_STEPS = 4;
  localparam int unsigned DIV_ITER  = VALUE_WIDTH / DIV_STEPS;
  localparam int unsigned DIV_CNT_W = (DIV_ITER > 1) ? $clog2(DIV_ITER) : 1;

  localparam int unsigned DIGIT_IDX_W = $clog2(DIGIT_DEPTH);
  localparam int unsigned COUNT_W     = $clog2(DIGIT_DEPTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  localparam int unsigned FLAG_UNSIGNED = 0;
  localparam int unsigned FLAG_LOWER    = 1;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);

  // Map one digit to its ASCII character in the requested letter case.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic lower);
    logic [CHAR_W-1:0] base_c;
    if (d < DIGIT_TEN) begin
      digit_char = CHAR_ZERO + CHAR_W'(d);
    end else begin
      base_c = lower ? CHAR_LOWER : CHAR_UPPER;
      digit_char = base_c + CHAR_W'(d - DIGIT_TEN);
    end
  endfunction

endpackage

FILE: sv/rita_divider.sv
// Iterative restoring divider: magnitude by radix, several quotient bits per cycle.
module rita_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rita_pkg::VALUE_WIDTH-1:0]    dividend_i,
  input  logic [rita_pkg::RADIX_W-1:0]        divisor_i,
  output logic                                done_o,
  output logic [rita_pkg::VALUE_WIDTH-1:0]    quotient_o,
  output logic [rita_pkg::DIGIT_W-1:0]        remainder_o
);

  logic [rita_pkg::VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [rita_pkg::DIGIT_W-1:0]     rem_q, rem_d;
  logic [rita_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic                             run_q;
  logic                             done_q;

  // Shift in one dividend bit per step, subtract the divisor where it fits.
  always_comb begin
    logic [rita_pkg::DIGIT_W:0] trial;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int s = 0; s < rita_pkg::DIV_STEPS; s++) begin
      trial = {rem_d, quo_d[rita_pkg::VALUE_WIDTH-1]};
      quo_d = {quo_d[rita_pkg::VALUE_WIDTH-2:0], 1'b0};
      if (trial >= divisor_i) begin
        trial    = trial - divisor_i;
        quo_d[0] = 1'b1;
      end
      rem_d = trial[rita_pkg::DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + rita_pkg::DIV_CNT_W'(1);
        if (cnt_q == rita_pkg::DIV_CNT_W'(rita_pkg::DIV_ITER - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

FILE: sv/radix_integer_to_ascii.sv
// Radix integer to ASCII converter: top level with sequencer and digit store.
//
// Usage: drive value_i, base_i and format_flags_i and raise start; the request
// is taken at a rising edge where start is high and busy is low. busy stays
// high until the last character of the text has been sent.
// format_flags_i bit 0 reads value_i as unsigned, bit 1 selects lower-case
// letters. A base below 2 counts as 2, above 16 as 16.
// Each character appears on character_o for exactly one cycle with strobe_o
// high; last_o marks the final character. A negative signed value starts with
// '-'. The receiver cannot stall: characters come one per cycle.
// Each digit takes one pass of the shared divider (8 steps of 4 quotient bits,
// plus launch and hand-back). The text has one character per digit, one more
// for a minus sign; the final character shows in the first cycle with busy
// low. The slowest request is -2^31 in base 2. No new request is taken while
// busy is high.
// Reset clears the sequencer, the digit count and the output strobe; the
// block is idle and ready right after reset.
module radix_integer_to_ascii (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [31:0]                value_i,
  input  logic [rita_pkg::RADIX_W-1:0]      base_i,
  input  logic [rita_pkg::FLAGS_W-1:0]      format_flags_i,
  output logic                              strobe_o,
  output logic [rita_pkg::CHAR_W-1:0]       character_o,
  output logic                              last_o
);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                          state_q, state_d;
  logic [rita_pkg::COUNT_W-1:0]        count_q, count_d;
  logic                                sign_q, sign_d;
  logic                                div_start_q, div_start_d;
  logic                                strobe_q, strobe_d;
  logic [rita_pkg::VALUE_WIDTH-1:0]    mag_q, mag_d;
  logic [rita_pkg::RADIX_W-1:0]        radix_q, radix_d;
  logic                                lower_q, lower_d;
  logic [rita_pkg::CHAR_W-1:0]         char_q, char_d;
  logic                                last_q, last_d;

  // Digit store, least significant digit at index 0
  logic [rita_pkg::DIGIT_W-1:0]        store [rita_pkg::DIGIT_DEPTH];
  logic                                store_we;
  logic [rita_pkg::DIGIT_IDX_W-1:0]    store_waddr;
  logic [rita_pkg::DIGIT_IDX_W-1:0]    store_raddr;
  logic [rita_pkg::COUNT_W-1:0]        count_m1;
  logic [rita_pkg::COUNT_W-1:0]        rd_count;
  logic [rita_pkg::DIGIT_W-1:0]        store_rdata_q;

  logic [rita_pkg::VALUE_WIDTH-1:0]    val_bits;
  logic [rita_pkg::RADIX_W-1:0]        base_clamped;
  logic                                div_done;
  logic [rita_pkg::VALUE_WIDTH-1:0]    div_quo;
  logic [rita_pkg::DIGIT_W-1:0]        div_rem;
  logic [rita_pkg::COUNT_W-1:0]        count_inc;

  assign val_bits = value_i;

  // Clamp the radix into 2..16
  always_comb begin
    priority if (base_i < rita_pkg::RADIX_MIN) begin
      base_clamped = rita_pkg::RADIX_MIN;
    end else if (base_i > rita_pkg::RADIX_MAX) begin
      base_clamped = rita_pkg::RADIX_MAX;
    end else begin
      base_clamped = base_i;
    end
  end

  assign count_inc   = count_q + rita_pkg::COUNT_W'(1);
  assign count_m1    = count_q - rita_pkg::COUNT_W'(1);
  // Prefetch the digit that the next count points at
  assign rd_count    = count_d - rita_pkg::COUNT_W'(1);
  assign store_waddr = count_q[rita_pkg::DIGIT_IDX_W-1:0];
  assign store_raddr = rd_count[rita_pkg::DIGIT_IDX_W-1:0];

  rita_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start_q),
    .dividend_i  (mag_q),
    .divisor_i   (radix_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sign_d      = sign_q;
    div_start_d = 1'b0;
    strobe_d    = 1'b0;
    mag_d       = mag_q;
    radix_d     = radix_q;
    lower_d     = lower_q;
    char_d      = char_q;
    last_d      = last_q;
    store_we    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          // Latch the request and launch the first division
          radix_d = base_clamped;
          lower_d = format_flags_i[rita_pkg::FLAG_LOWER];
          sign_d  = !format_flags_i[rita_pkg::FLAG_UNSIGNED]
                    && val_bits[rita_pkg::VALUE_WIDTH-1];
          mag_d   = sign_d ? (~val_bits + rita_pkg::VALUE_WIDTH'(1)) : val_bits;
          count_d = '0;
          div_start_d = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          // Store the remainder as the next digit, continue on the quotient
          store_we = 1'b1;
          mag_d    = div_quo;
          count_d  = count_inc;
          if (div_quo == '0 ||
              count_inc == rita_pkg::COUNT_W'(rita_pkg::DIGIT_DEPTH)) begin
            state_d = ST_EMIT;
          end else begin
            div_start_d = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        strobe_d = 1'b1;
        if (sign_q) begin
          char_d = rita_pkg::CHAR_MINUS;
          last_d = 1'b0;
          sign_d = 1'b0;
        end else begin
          // Drain digits most significant first
          char_d  = rita_pkg::digit_char(store_rdata_q, lower_q);
          last_d  = (count_q == rita_pkg::COUNT_W'(1));
          count_d = count_m1;
          if (count_q == rita_pkg::COUNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sign_q      <= 1'b0;
      div_start_q <= 1'b0;
      strobe_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sign_q      <= sign_d;
      div_start_q <= div_start_d;
      strobe_q    <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q   <= mag_d;
    radix_q <= radix_d;
    lower_q <= lower_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  // A write always targets the prefetch address, so forward the new digit
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store[store_waddr] <= div_rem;
      store_rdata_q      <= div_rem;
    end else begin
      store_rdata_q      <= store[store_raddr];
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // The final character leaves the block idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && last_o |-> !busy)
    else $error("block still busy on final character");

  // A character that is not the final one leaves more text pending
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy)
    else $error("block idle with text still pending");

  // An accepted request always starts a division pass
  a_accept_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && div_start_q)
    else $error("accepted request did not launch the divider");

  // The digit count never passes the store depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rita_pkg::COUNT_W'(rita_pkg::DIGIT_DEPTH))
    else $error("digit count beyond store depth");

endmodule

FILE: test/itoa_text_checker.sv
// Checker for the integer to ASCII converter: predicts each request's text and compares it.
module itoa_text_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [31:0]                  value_i,
  input  logic [rita_pkg::RADIX_W-1:0] base_i,
  input  logic [rita_pkg::FLAGS_W-1:0] format_flags_i,
  input  logic                         strobe_i,
  input  logic [rita_pkg::CHAR_W-1:0]  character_i,
  input  logic                         last_i,
  output int                           pending_o,
  output int                           errors_o
);

  typedef struct packed {
    logic [rita_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } text_char_t;

  text_char_t expected_text[$];

  // Append the full text of one request, sign first, most significant digit next.
  function automatic void queue_text(input logic [31:0] v,
                                     input logic [rita_pkg::RADIX_W-1:0] b,
                                     input logic [rita_pkg::FLAGS_W-1:0] f);
    logic [3:0]  digits [32];
    logic [31:0] mag;
    logic [31:0] radix;
    logic        negative;
    logic        lower;
    int          count;
    text_char_t  tc;
    if (b < 2) begin
      radix = 2;
    end else if (b > 16) begin
      radix = 16;
    end else begin
      radix = 32'(b);
    end
    negative = !f[rita_pkg::FLAG_UNSIGNED] && v[31];
    lower    = f[rita_pkg::FLAG_LOWER];
    mag      = negative ? (~v + 32'd1) : v;
    count    = 0;
    do begin
      digits[count] = 4'(mag % radix);
      mag = mag / radix;
      count++;
    end while (mag != 0 && count < 32);
    if (negative) begin
      tc.ch   = "-";
      tc.last = 1'b0;
      expected_text.push_back(tc);
    end
    for (int i = count - 1; i >= 0; i--) begin
      if (digits[i] < 10) begin
        tc.ch = 8'h30 + 8'(digits[i]);
      end else begin
        tc.ch = (lower ? 8'h61 : 8'h41) + 8'(digits[i]) - 8'd10;
      end
      tc.last = (i == 0);
      expected_text.push_back(tc);
    end
  endfunction

  // Compare outgoing characters before queueing a new request, so order holds.
  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      expected_text.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (strobe_i) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual %h last %b",
                   $time, character_i, last_i);
          errors_o++;
        end else begin
          want = expected_text.pop_front();
          if (character_i !== want.ch) begin
            $display("%0t: character mismatch: expected %h, actual %h",
                     $time, want.ch, character_i);
            errors_o++;
          end
          if (last_i !== want.last) begin
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, want.last, last_i);
            errors_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        queue_text(value_i, base_i, format_flags_i);
      end
      pending_o = expected_text.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// Testbench top for the radix integer to ASCII converter: stimulus and verdict.
module tb_top;

  // Format flag encodings built from the package bit positions.
  localparam logic [rita_pkg::FLAGS_W-1:0] FMT_SIGNED   = '0;
  localparam logic [rita_pkg::FLAGS_W-1:0] FMT_UNSIGNED =
    rita_pkg::FLAGS_W'(1 << rita_pkg::FLAG_UNSIGNED);
  localparam logic [rita_pkg::FLAGS_W-1:0] FMT_LOWER    =
    rita_pkg::FLAGS_W'(1 << rita_pkg::FLAG_LOWER);

  localparam int RANDOM_REQUESTS = 440;
  // Idle tail after the last text, longer than the slowest request keeps the block busy.
  localparam int TAIL_CYCLES     = 400;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic [31:0]                  value_i = '0;
  logic [rita_pkg::RADIX_W-1:0] base_i = '0;
  logic [rita_pkg::FLAGS_W-1:0] format_flags_i = '0;
  logic                         strobe_o;
  logic [rita_pkg::CHAR_W-1:0]  character_o;
  logic                         last_o;
  int                           pending;
  int                           errors;
  int                           burst_left = 0;

  always #5 clk_i = ~clk_i;

  radix_integer_to_ascii uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_i        (value_i),
    .base_i         (base_i),
    .format_flags_i (format_flags_i),
    .strobe_o       (strobe_o),
    .character_o    (character_o),
    .last_o         (last_o)
  );

  itoa_text_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .value_i        (value_i),
    .base_i         (base_i),
    .format_flags_i (format_flags_i),
    .strobe_i       (strobe_o),
    .character_i    (character_o),
    .last_i         (last_o),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  // Issue one request. Called at a falling edge; returns at a falling edge with
  // start still high, so a back-to-back request keeps it up without a glitch.
  task automatic send_request(input logic [31:0] v,
                              input logic [rita_pkg::RADIX_W-1:0] b,
                              input logic [rita_pkg::FLAGS_W-1:0] f);
    int gap;
    // Alternate random idle gaps with bursts of back-to-back requests.
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 24) == 0) burst_left = $urandom_range(5, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start          <= 1'b1;
    value_i        <= v;
    base_i         <= b;
    format_flags_i <= f;
    // Hold the request until the block takes it.
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Drop start and hold off until every queued character has come out.
  task automatic drain_text();
    start <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  initial begin
    logic [31:0]                  v;
    logic [rita_pkg::RADIX_W-1:0] b;
    logic [rita_pkg::FLAGS_W-1:0] f;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero, the extremes of each field, every flag setting, clamping.
    send_request(32'd0, 5'd10, FMT_SIGNED);
    send_request(32'd0, 5'd2, FMT_UNSIGNED | FMT_LOWER);
    send_request(32'h7FFF_FFFF, 5'd2, FMT_SIGNED);
    send_request(32'h8000_0000, 5'd2, FMT_SIGNED);        // most negative, binary
    send_request(32'h8000_0000, 5'd10, FMT_SIGNED);
    send_request(32'h8000_0000, 5'd16, FMT_LOWER);
    send_request(32'hFFFF_FFFF, 5'd2, FMT_UNSIGNED);      // 32 digits, no sign
    send_request(32'hFFFF_FFFF, 5'd10, FMT_SIGNED);       // minus one
    send_request(32'hFFFF_FFFF, 5'd16, FMT_UNSIGNED);
    send_request(32'hFFFF_FFFF, 5'd16, FMT_UNSIGNED | FMT_LOWER);
    send_request(32'hABCD_EF01, 5'd16, FMT_UNSIGNED);
    send_request(32'hABCD_EF01, 5'd16, FMT_SIGNED | FMT_LOWER);
    send_request(32'd12345, 5'd0, FMT_SIGNED);            // base below range
    send_request(32'd12345, 5'd1, FMT_LOWER);
    send_request(32'hDEAD_BEEF, 5'd17, FMT_UNSIGNED);     // base above range
    send_request(32'hDEAD_BEEF, 5'd31, FMT_UNSIGNED | FMT_LOWER);
    drain_text();
    send_request(32'd1_000_000, 5'd3, FMT_SIGNED);
    send_request(32'd987_654, 5'd7, FMT_LOWER);
    send_request(-32'sd31415, 5'd11, FMT_SIGNED);
    send_request(32'd255, 5'd15, FMT_LOWER);
    send_request(32'd15, 5'd16, FMT_SIGNED);
    send_request(32'd9, 5'd10, FMT_UNSIGNED);

    // Random: mostly in-range bases, a mix of value shapes.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      case ($urandom_range(0, 5))
        0, 1: v = $urandom();
        2:    v = $urandom_range(0, 255);
        3:    v = -$urandom_range(1, 1000);
        4:    v = $urandom() >> $urandom_range(0, 31);
        default: begin
          case ($urandom_range(0, 4))
            0:       v = 32'h0000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h8000_0000;
            3:       v = 32'hFFFF_FFFF;
            default: v = 32'h8000_0001;
          endcase
        end
      endcase
      if ($urandom_range(0, 9) == 0) begin
        b = rita_pkg::RADIX_W'($urandom_range(0, 31));
      end else begin
        b = rita_pkg::RADIX_W'($urandom_range(2, 16));
      end
      f = rita_pkg::FLAGS_W'($urandom_range(0, 3));
      send_request(v, b, f);
      if ($urandom_range(0, 29) == 0) drain_text();
    end

    start <= 1'b0;
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Bound the run well past the slowest legal completion.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: radix_integer_to_ascii.f
sv/rita_pkg.sv
sv/rita_divider.sv
sv/radix_integer_to_ascii.sv
test/itoa_text_checker.sv
test/tb_top.sv
